// ===== rtl/irpdr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the infrared-to-depth pixel registration block.
// No dependencies; every other file but irpdr_mem refers to this package by scoped names.
package irpdr_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    localparam int CFG_DW = 64;
    localparam int CFG_IW = 3;

    // Shared divider: signed aligned dividend, signed divisor, magnitude widths
    localparam int DIV_NW = 73;
    localparam int DIV_MW = 72;
    localparam int DIV_DW = 41;
    localparam int DIV_RW = 40;
    localparam int DIV_CW = 7;

    // Shared multiplier
    localparam int MUL_AW = 17;
    localparam int MUL_BW = 64;
    localparam int MUL_PW = 81;

    // Quotient bits worked per division kind
    localparam logic [DIV_CW-1:0] DIV_IT_RAY = DIV_CW'(32);
    localparam logic [DIV_CW-1:0] DIV_IT_PRJ = DIV_CW'(63);
    localparam logic [DIV_CW-1:0] DIV_IT_PNT = DIV_CW'(71);

    localparam logic signed [23:0] MISS_COORD = -24'sd4096;

    typedef enum logic [CFG_IW-1:0] {
        REG_IR_INTR  = 3'd0,
        REG_DP_INTR  = 3'd1,
        REG_ROT0     = 3'd2,
        REG_ROT1     = 3'd3,
        REG_ROT2     = 3'd4,
        REG_TRANS    = 3'd5,
        REG_DWIDTH   = 3'd6,
        REG_DHEIGHT  = 3'd7
    } cfg_reg_t;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [7:0]  depth_col;
        logic [7:0]  depth_row;
        logic [15:0] depth_data;
        logic [11:0] ir_u;
        logic [11:0] ir_v;
    } item_t;

    typedef struct packed {
        logic               hit;
        logic [7:0]         hit_col;
        logic [7:0]         hit_row;
        logic signed [23:0] point_x;
        logic signed [23:0] point_y;
        logic signed [23:0] point_z;
    } result_t;

    typedef struct packed {
        logic [63:0] ir_intr;
        logic [63:0] dp_intr;
        logic [47:0] rot0;
        logic [47:0] rot1;
        logic [47:0] rot2;
        logic [47:0] trans;
        logic [8:0]  dwidth;
        logic [8:0]  dheight;
    } cfg_t;

    typedef struct packed {
        logic                     start;
        logic signed [DIV_NW-1:0] num;
        logic signed [DIV_DW-1:0] den;
        logic [DIV_CW-1:0]        iters;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [DIV_NW-1:0] quo;
    } div_rsp_t;

    typedef enum logic [1:0] {
        DV_IDLE = 2'd0,
        DV_RUN  = 2'd1,
        DV_FIN  = 2'd2
    } div_state_t;

    typedef enum logic [4:0] {
        S_IDLE  = 5'd0,
        S_CHK   = 5'd1,
        S_DVX   = 5'd2,
        S_DVY   = 5'd3,
        S_ROT_M = 5'd4,
        S_ROT_A = 5'd5,
        S_ROT_R = 5'd6,
        S_RZC   = 5'd7,
        S_QXM   = 5'd8,
        S_QXD   = 5'd9,
        S_QYM   = 5'd10,
        S_QYD   = 5'd11,
        S_UV    = 5'd12,
        S_BND   = 5'd13,
        S_RD    = 5'd14,
        S_DEP   = 5'd15,
        S_PXM   = 5'd16,
        S_PXD   = 5'd17,
        S_PYM   = 5'd18,
        S_PYD   = 5'd19,
        S_MISS  = 5'd20
    } state_t;

    function automatic logic signed [23:0] sat24(input logic signed [DIV_NW-1:0] v);
        logic signed [23:0] r;
        if (v > 73'sd8388607)
            r = 24'sh7FFFFF;
        else if (v < -73'sd8388608)
            r = 24'sh800000;
        else
            r = v[23:0];
        return r;
    endfunction

endpackage

// ===== rtl/irpdr_div.sv =====
`timescale 1ns / 1ps
// Shared signed divider, restoring, one quotient bit per cycle, truncates toward zero.
// Depends on irpdr_pkg for the request and response types.
module irpdr_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  irpdr_pkg::div_req_t req,
    output irpdr_pkg::div_rsp_t rsp
);

    irpdr_pkg::div_state_t st_reg, st_next;

    logic [irpdr_pkg::DIV_MW-1:0]        num_reg, num_next;
    logic [irpdr_pkg::DIV_RW-1:0]        den_reg, den_next;
    logic [irpdr_pkg::DIV_RW-1:0]        rem_reg, rem_next;
    logic [irpdr_pkg::DIV_MW-1:0]        quo_reg, quo_next;
    logic [irpdr_pkg::DIV_CW-1:0]        cnt_reg, cnt_next;
    logic                                neg_reg, neg_next;
    logic signed [irpdr_pkg::DIV_NW-1:0] q_reg, q_next;
    logic                                done_reg, done_next;

    logic [irpdr_pkg::DIV_NW-1:0] num_abs;
    logic [irpdr_pkg::DIV_DW-1:0] den_abs;
    logic [irpdr_pkg::DIV_RW:0]   rem_t;
    logic [irpdr_pkg::DIV_RW:0]   rem_d;
    logic                         ge;

    assign num_abs = req.num[irpdr_pkg::DIV_NW-1] ? (irpdr_pkg::DIV_NW'(0) - req.num) : req.num;
    assign den_abs = req.den[irpdr_pkg::DIV_DW-1] ? (irpdr_pkg::DIV_DW'(0) - req.den) : req.den;
    assign rem_t   = {rem_reg, num_reg[irpdr_pkg::DIV_MW-1]};
    assign rem_d   = rem_t - {1'b0, den_reg};
    assign ge      = (rem_t >= {1'b0, den_reg});

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            irpdr_pkg::DV_IDLE: if (req.start) st_next = irpdr_pkg::DV_RUN;
            irpdr_pkg::DV_RUN:  if (cnt_reg == irpdr_pkg::DIV_CW'(1)) st_next = irpdr_pkg::DV_FIN;
            irpdr_pkg::DV_FIN:  st_next = irpdr_pkg::DV_IDLE;
            default:            st_next = irpdr_pkg::DV_IDLE;
        endcase
    end

    always_comb
    begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        q_next    = q_reg;
        done_next = 1'b0;
        case (st_reg)
            irpdr_pkg::DV_IDLE:
            begin
                if (req.start)
                begin
                    num_next = num_abs[irpdr_pkg::DIV_MW-1:0];
                    den_next = den_abs[irpdr_pkg::DIV_RW-1:0];
                    rem_next = '0;
                    quo_next = '0;
                    cnt_next = req.iters;
                    neg_next = req.num[irpdr_pkg::DIV_NW-1] ^ req.den[irpdr_pkg::DIV_DW-1];
                end
            end
            irpdr_pkg::DV_RUN:
            begin
                rem_next = ge ? rem_d[irpdr_pkg::DIV_RW-1:0] : rem_t[irpdr_pkg::DIV_RW-1:0];
                num_next = {num_reg[irpdr_pkg::DIV_MW-2:0], 1'b0};
                quo_next = {quo_reg[irpdr_pkg::DIV_MW-2:0], ge};
                cnt_next = cnt_reg - irpdr_pkg::DIV_CW'(1);
            end
            irpdr_pkg::DV_FIN:
            begin
                // apply the sign to the magnitude quotient
                q_next    = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
                done_next = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= irpdr_pkg::DV_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
        q_reg   <= q_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = q_reg;

endmodule

// ===== rtl/irpdr_mul.sv =====
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
// Depends on irpdr_pkg for the operand widths.
module irpdr_mul
(
    input  logic                               clk,
    input  logic signed [irpdr_pkg::MUL_AW-1:0] a,
    input  logic signed [irpdr_pkg::MUL_BW-1:0] b,
    output logic signed [irpdr_pkg::MUL_PW-1:0] p
);

    logic signed [irpdr_pkg::MUL_PW-1:0] p_reg, p_next;

    assign p_next = a * b;

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

// ===== rtl/irpdr_mem.sv =====
`timescale 1ns / 1ps
// Depth store: single write port, single registered read port.
// No package dependency; sized by its parameters.
module irpdr_mem
#(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [15:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [15:0]   rdata
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/irpdr_core.sv =====
`timescale 1ns / 1ps
// Query sequencer and datapath registers; drives the shared multiplier and divider.
// Depends on irpdr_pkg, irpdr_mul and irpdr_div.
module irpdr_core
#(
    parameter int MAX_WIDTH  = irpdr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = irpdr_pkg::MAX_HEIGHT_DEF,
    parameter int AW         = $clog2(MAX_WIDTH * MAX_HEIGHT)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                query,
    input  logic [11:0]         u,
    input  logic [11:0]         v,
    input  irpdr_pkg::cfg_t     cfg,
    input  logic [15:0]         rdata,
    output logic [AW-1:0]       raddr,
    output logic                busy,
    output logic                done,
    output irpdr_pkg::result_t  result
);

    localparam int WL_W = $clog2((MAX_WIDTH > 511 ? MAX_WIDTH : 511) + 1);
    localparam int HL_W = $clog2((MAX_HEIGHT > 511 ? MAX_HEIGHT : 511) + 1);

    irpdr_pkg::state_t state_reg, state_next;

    logic [11:0]        u_reg, u_next, v_reg, v_next;
    logic signed [35:0] d0_reg, d0_next, d1_reg, d1_next, d2_reg, d2_next;
    logic signed [55:0] acc_reg, acc_next;
    logic signed [39:0] rx_reg, rx_next, ry_reg, ry_next, rz_reg, rz_next;
    logic signed [63:0] qx_reg, qx_next, qy_reg, qy_next;
    logic signed [65:0] uq_reg, uq_next, vq_reg, vq_next;
    logic [15:0]        dep_reg, dep_next;
    logic signed [23:0] px_reg, px_next;
    logic [1:0]         ri_reg, ri_next, rj_reg, rj_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic [7:0]         col_reg, col_next, row_reg, row_next;
    irpdr_pkg::result_t res_reg, res_next;
    logic               done_reg, done_next;

    logic [15:0] fx, fy, cx, cy, fxd, fyd, cxd, cyd;
    logic signed [15:0] tr0, tr1, tr2;
    logic        focal_zero, rz_zero, bnd_hit;

    logic signed [irpdr_pkg::MUL_AW-1:0] mul_a;
    logic signed [irpdr_pkg::MUL_BW-1:0] mul_b;
    logic signed [irpdr_pkg::MUL_PW-1:0] mul_p;
    irpdr_pkg::div_req_t div_req;
    irpdr_pkg::div_rsp_t div_rsp;

    logic [47:0]        rot_row;
    logic signed [15:0] rot_e;
    logic signed [35:0] d_sel;
    logic signed [72:0] diffx, diffy;
    logic signed [55:0] acc_b;
    logic signed [80:0] p_b;
    logic signed [72:0] p_t;
    logic [WL_W-1:0]    dw_ext, wlim, col;
    logic [HL_W-1:0]    dh_ext, hlim, row;
    logic               u_ok, v_ok;

    assign fx  = cfg.ir_intr[15:0];
    assign fy  = cfg.ir_intr[31:16];
    assign cx  = cfg.ir_intr[47:32];
    assign cy  = cfg.ir_intr[63:48];
    assign fxd = cfg.dp_intr[15:0];
    assign fyd = cfg.dp_intr[31:16];
    assign cxd = cfg.dp_intr[47:32];
    assign cyd = cfg.dp_intr[63:48];
    assign tr0 = cfg.trans[15:0];
    assign tr1 = cfg.trans[31:16];
    assign tr2 = cfg.trans[47:32];

    assign focal_zero = (fx == '0) || (fy == '0) || (fxd == '0) || (fyd == '0);
    assign rz_zero    = (rz_reg == '0);

    // Ray numerators; their low 17 bits are aligned to the top of the divider's dividend
    assign diffx = $signed({57'd0, u_reg, 4'd0}) - $signed({57'd0, cx});
    assign diffy = $signed({57'd0, v_reg, 4'd0}) - $signed({57'd0, cy});

    always_comb
    begin
        case (ri_reg)
            2'd0:    rot_row = cfg.rot0;
            2'd1:    rot_row = cfg.rot1;
            default: rot_row = cfg.rot2;
        endcase
    end

    always_comb
    begin
        case (rj_reg)
            2'd0:
            begin
                rot_e = rot_row[15:0];
                d_sel = d0_reg;
            end
            2'd1:
            begin
                rot_e = rot_row[31:16];
                d_sel = d1_reg;
            end
            default:
            begin
                rot_e = rot_row[47:32];
                d_sel = d2_reg;
            end
        endcase
    end

    // Truncate toward zero on the power-of-two scalings
    assign acc_b = acc_reg + (acc_reg[55] ? 56'sd16383 : 56'sd0);
    assign p_b   = mul_p + (mul_p[80] ? 81'sd255 : 81'sd0);
    assign p_t   = p_b[80:8];

    // Bounds on the projected pixel, truncated toward zero
    assign dw_ext = WL_W'(cfg.dwidth);
    assign dh_ext = HL_W'(cfg.dheight);
    assign wlim   = (dw_ext < WL_W'(MAX_WIDTH)) ? dw_ext : WL_W'(MAX_WIDTH);
    assign hlim   = (dh_ext < HL_W'(MAX_HEIGHT)) ? dh_ext : HL_W'(MAX_HEIGHT);
    assign u_ok   = (uq_reg > -66'sd4096)
                  && (uq_reg < $signed({{(54 - WL_W){1'b0}}, wlim, 12'd0}));
    assign v_ok   = (vq_reg > -66'sd4096)
                  && (vq_reg < $signed({{(54 - HL_W){1'b0}}, hlim, 12'd0}));
    assign col    = uq_reg[65] ? '0 : uq_reg[12 +: WL_W];
    assign row    = vq_reg[65] ? '0 : vq_reg[12 +: HL_W];
    assign bnd_hit = u_ok && v_ok;

    irpdr_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    irpdr_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            irpdr_pkg::S_IDLE:  if (query) state_next = irpdr_pkg::S_CHK;
            irpdr_pkg::S_CHK:   state_next = focal_zero ? irpdr_pkg::S_MISS : irpdr_pkg::S_DVX;
            irpdr_pkg::S_DVX:   if (div_rsp.done) state_next = irpdr_pkg::S_DVY;
            irpdr_pkg::S_DVY:   if (div_rsp.done) state_next = irpdr_pkg::S_ROT_M;
            irpdr_pkg::S_ROT_M: state_next = irpdr_pkg::S_ROT_A;
            irpdr_pkg::S_ROT_A:
                state_next = (rj_reg == 2'd2) ? irpdr_pkg::S_ROT_R : irpdr_pkg::S_ROT_M;
            irpdr_pkg::S_ROT_R:
                state_next = (ri_reg == 2'd2) ? irpdr_pkg::S_RZC : irpdr_pkg::S_ROT_M;
            irpdr_pkg::S_RZC:   state_next = rz_zero ? irpdr_pkg::S_MISS : irpdr_pkg::S_QXM;
            irpdr_pkg::S_QXM:   state_next = irpdr_pkg::S_QXD;
            irpdr_pkg::S_QXD:   if (div_rsp.done) state_next = irpdr_pkg::S_QYM;
            irpdr_pkg::S_QYM:   state_next = irpdr_pkg::S_QYD;
            irpdr_pkg::S_QYD:   if (div_rsp.done) state_next = irpdr_pkg::S_UV;
            irpdr_pkg::S_UV:    state_next = irpdr_pkg::S_BND;
            irpdr_pkg::S_BND:   state_next = bnd_hit ? irpdr_pkg::S_RD : irpdr_pkg::S_MISS;
            irpdr_pkg::S_RD:    state_next = irpdr_pkg::S_DEP;
            irpdr_pkg::S_DEP:   state_next = irpdr_pkg::S_PXM;
            irpdr_pkg::S_PXM:   state_next = irpdr_pkg::S_PXD;
            irpdr_pkg::S_PXD:   if (div_rsp.done) state_next = irpdr_pkg::S_PYM;
            irpdr_pkg::S_PYM:   state_next = irpdr_pkg::S_PYD;
            irpdr_pkg::S_PYD:   if (div_rsp.done) state_next = irpdr_pkg::S_IDLE;
            irpdr_pkg::S_MISS:  state_next = irpdr_pkg::S_IDLE;
            default:            state_next = irpdr_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        u_next    = u_reg;
        v_next    = v_reg;
        d0_next   = d0_reg;
        d1_next   = d1_reg;
        d2_next   = d2_reg;
        acc_next  = acc_reg;
        rx_next   = rx_reg;
        ry_next   = ry_reg;
        rz_next   = rz_reg;
        qx_next   = qx_reg;
        qy_next   = qy_reg;
        uq_next   = uq_reg;
        vq_next   = vq_reg;
        dep_next  = dep_reg;
        px_next   = px_reg;
        ri_next   = ri_reg;
        rj_next   = rj_reg;
        addr_next = addr_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        res_next  = res_reg;
        done_next = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_req   = '0;
        case (state_reg)
            irpdr_pkg::S_IDLE:
            begin
                if (query)
                begin
                    u_next = u;
                    v_next = v;
                end
            end
            irpdr_pkg::S_CHK:
            begin
                div_req.start = !focal_zero;
                div_req.num   = {diffx[16:0], 56'd0};
                div_req.den   = $signed({25'd0, fx});
                div_req.iters = irpdr_pkg::DIV_IT_RAY;
            end
            irpdr_pkg::S_DVX:
            begin
                if (div_rsp.done)
                begin
                    d0_next       = $signed(div_rsp.quo[35:0])
                                  - $signed({{16{tr0[15]}}, tr0, 4'd0});
                    div_req.start = 1'b1;
                    div_req.num   = {diffy[16:0], 56'd0};
                    div_req.den   = $signed({25'd0, fy});
                    div_req.iters = irpdr_pkg::DIV_IT_RAY;
                end
            end
            irpdr_pkg::S_DVY:
            begin
                if (div_rsp.done)
                begin
                    d1_next  = $signed(div_rsp.quo[35:0])
                             - $signed({{16{tr1[15]}}, tr1, 4'd0});
                    d2_next  = 36'sd65536 - $signed({{16{tr2[15]}}, tr2, 4'd0});
                    acc_next = '0;
                    ri_next  = 2'd0;
                    rj_next  = 2'd0;
                end
            end
            irpdr_pkg::S_ROT_M:
            begin
                mul_a = {rot_e[15], rot_e};
                mul_b = {{28{d_sel[35]}}, d_sel};
            end
            irpdr_pkg::S_ROT_A:
            begin
                acc_next = acc_reg + mul_p[55:0];
                rj_next  = (rj_reg == 2'd2) ? 2'd0 : rj_reg + 2'd1;
            end
            irpdr_pkg::S_ROT_R:
            begin
                case (ri_reg)
                    2'd0:    rx_next = acc_b[53:14];
                    2'd1:    ry_next = acc_b[53:14];
                    default: rz_next = acc_b[53:14];
                endcase
                acc_next = '0;
                ri_next  = ri_reg + 2'd1;
            end
            irpdr_pkg::S_RZC:
            begin
                mul_a = $signed({1'b0, fxd});
                mul_b = {{24{rx_reg[39]}}, rx_reg};
            end
            irpdr_pkg::S_QXM:
            begin
                div_req.start = 1'b1;
                div_req.num   = {mul_p[55:0], 17'd0};
                div_req.den   = {rz_reg[39], rz_reg};
                div_req.iters = irpdr_pkg::DIV_IT_PRJ;
            end
            irpdr_pkg::S_QXD:
            begin
                mul_a = $signed({1'b0, fyd});
                mul_b = {{24{ry_reg[39]}}, ry_reg};
                if (div_rsp.done)
                    qx_next = div_rsp.quo[63:0];
            end
            irpdr_pkg::S_QYM:
            begin
                div_req.start = 1'b1;
                div_req.num   = {mul_p[55:0], 17'd0};
                div_req.den   = {rz_reg[39], rz_reg};
                div_req.iters = irpdr_pkg::DIV_IT_PRJ;
            end
            irpdr_pkg::S_QYD:
            begin
                if (div_rsp.done)
                    qy_next = div_rsp.quo[63:0];
            end
            irpdr_pkg::S_UV:
            begin
                uq_next = {{2{qx_reg[63]}}, qx_reg} + $signed({42'd0, cxd, 8'd0});
                vq_next = {{2{qy_reg[63]}}, qy_reg} + $signed({42'd0, cyd, 8'd0});
            end
            irpdr_pkg::S_BND:
            begin
                addr_next = AW'(row) * AW'(MAX_WIDTH) + AW'(col);
                col_next  = col[7:0];
                row_next  = row[7:0];
            end
            irpdr_pkg::S_DEP:
            begin
                dep_next = rdata;
                mul_a    = $signed({1'b0, rdata});
                mul_b    = qx_reg;
            end
            irpdr_pkg::S_PXM:
            begin
                div_req.start = 1'b1;
                div_req.num   = {p_t[71:0], 1'b0};
                div_req.den   = $signed({25'd0, fxd});
                div_req.iters = irpdr_pkg::DIV_IT_PNT;
            end
            irpdr_pkg::S_PXD:
            begin
                mul_a = $signed({1'b0, dep_reg});
                mul_b = qy_reg;
                if (div_rsp.done)
                    px_next = irpdr_pkg::sat24(div_rsp.quo);
            end
            irpdr_pkg::S_PYM:
            begin
                div_req.start = 1'b1;
                div_req.num   = {p_t[71:0], 1'b0};
                div_req.den   = $signed({25'd0, fyd});
                div_req.iters = irpdr_pkg::DIV_IT_PNT;
            end
            irpdr_pkg::S_PYD:
            begin
                if (div_rsp.done)
                begin
                    res_next.hit     = 1'b1;
                    res_next.hit_col = col_reg;
                    res_next.hit_row = row_reg;
                    res_next.point_x = px_reg;
                    res_next.point_y = irpdr_pkg::sat24(div_rsp.quo);
                    res_next.point_z = $signed({8'd0, dep_reg});
                    done_next        = 1'b1;
                end
            end
            irpdr_pkg::S_MISS:
            begin
                res_next.hit     = 1'b0;
                res_next.hit_col = '0;
                res_next.hit_row = '0;
                res_next.point_x = irpdr_pkg::MISS_COORD;
                res_next.point_y = irpdr_pkg::MISS_COORD;
                res_next.point_z = irpdr_pkg::MISS_COORD;
                done_next        = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= irpdr_pkg::S_IDLE;
            ri_reg    <= '0;
            rj_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ri_reg    <= ri_next;
            rj_reg    <= rj_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg    <= u_next;
        v_reg    <= v_next;
        d0_reg   <= d0_next;
        d1_reg   <= d1_next;
        d2_reg   <= d2_next;
        acc_reg  <= acc_next;
        rx_reg   <= rx_next;
        ry_reg   <= ry_next;
        rz_reg   <= rz_next;
        qx_reg   <= qx_next;
        qy_reg   <= qy_next;
        uq_reg   <= uq_next;
        vq_reg   <= vq_next;
        dep_reg  <= dep_next;
        px_reg   <= px_next;
        addr_reg <= addr_next;
        col_reg  <= col_next;
        row_reg  <= row_next;
        res_reg  <= res_next;
    end

    assign raddr  = addr_reg;
    assign busy   = (state_reg != irpdr_pkg::S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== rtl/ir_pixel_depth_registration.sv =====
`timescale 1ns / 1ps
// Top level: configuration registers, depth store and query sequencer.
// Depends on irpdr_pkg, irpdr_mem and irpdr_core.

// A transaction is taken when start is high and busy is low. A depth write
// completes in that cycle and busy stays low. A query holds busy until its result
// is given, sooner on an early miss: the shared one-bit-per-cycle divider
// works six divisions of 32, 63 and 71 quotient bits, and the shared multiplier
// forms the nine rotation products and four more. Each query gives one result,
// shown on result as done is high for a single cycle; it cannot be held
// off, so capture it on that cycle. Write configuration only while busy is low.
module ir_pixel_depth_registration
#(
    parameter int MAX_WIDTH  = irpdr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = irpdr_pkg::MAX_HEIGHT_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  irpdr_pkg::item_t              item,
    output logic                          busy,
    output logic                          done,
    output irpdr_pkg::result_t            result,
    input  logic                          cfg_we,
    input  logic [irpdr_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [irpdr_pkg::CFG_DW-1:0]  cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    irpdr_pkg::cfg_t cfg_reg, cfg_next;

    logic          accept;
    logic          wr_en;
    logic          query;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [15:0]   rdata;

    assign accept = start && !busy;
    assign query  = accept && (item.opcode == irpdr_pkg::OP_QUERY);
    // drop writes that fall outside the store
    assign wr_en  = accept && (item.opcode == irpdr_pkg::OP_WRITE)
                  && (int'(item.depth_col) < MAX_WIDTH)
                  && (int'(item.depth_row) < MAX_HEIGHT);
    assign waddr  = AW'(item.depth_row) * AW'(MAX_WIDTH) + AW'(item.depth_col);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (irpdr_pkg::cfg_reg_t'(cfg_index))
                irpdr_pkg::REG_IR_INTR: cfg_next.ir_intr = cfg_data;
                irpdr_pkg::REG_DP_INTR: cfg_next.dp_intr = cfg_data;
                irpdr_pkg::REG_ROT0:    cfg_next.rot0    = cfg_data[47:0];
                irpdr_pkg::REG_ROT1:    cfg_next.rot1    = cfg_data[47:0];
                irpdr_pkg::REG_ROT2:    cfg_next.rot2    = cfg_data[47:0];
                irpdr_pkg::REG_TRANS:   cfg_next.trans   = cfg_data[47:0];
                irpdr_pkg::REG_DWIDTH:  cfg_next.dwidth  = cfg_data[8:0];
                irpdr_pkg::REG_DHEIGHT: cfg_next.dheight = cfg_data[8:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{ir_intr: '0, dp_intr: '0, rot0: '0, rot1: '0, rot2: '0,
                         trans: '0, dwidth: 9'd256, dheight: 9'd256};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    irpdr_mem
    #(
        .DEPTH (DEPTH),
        .AW    (AW)
    )
    u_mem
    (
        .clk   (clk),
        .we    (wr_en),
        .waddr (waddr),
        .wdata (item.depth_data),
        .raddr (raddr),
        .rdata (rdata)
    );

    irpdr_core
    #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW)
    )
    u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query),
        .u      (item.ir_u),
        .v      (item.ir_v),
        .cfg    (cfg_reg),
        .rdata  (rdata),
        .raddr  (raddr),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a query in flight");

    a_query_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        query |=> busy)
        else $error("query accepted but sequencer stayed idle");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("more than one result for one query");

    a_miss_coords: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.hit) |-> (result.point_z == irpdr_pkg::MISS_COORD
                                   && result.hit_col == 8'd0))
        else $error("miss result without miss coordinates");

endmodule
